### design/mexp_pkg.sv
// Package for the modular exponentiation block.
// Holds the controller/datapath command and status structs and the modulus reset value.
// No dependencies.
package mexp_pkg;

    // Modulus after reset
    localparam logic [31:0] MODULUS_RESET = 32'd1000000007;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;        // capture a transaction and start the base reduction
        logic take_red;    // store the reduced base as the running square
        logic start_step;  // start one square and one multiply
        logic take_step;   // fold the products and shift the exponent
        logic push;        // load the result into the output register
    } t_dp_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic mul_done;    // the square product unit has finished
        logic exp_zero;    // no set exponent bits remain
        logic out_free;    // the output register can take a result
    } t_dp_status;

endpackage

### design/mexp_if.sv
// Channel interfaces for the modular exponentiation block.
// Request carries base and exponent, response carries the result; no dependencies.
interface mexp_req_if #(
    parameter int EXP_BITS = 63,
    parameter int MOD_BITS = 31
);
    logic                valid;
    logic                ready;
    logic [MOD_BITS-1:0] base_value;
    logic [EXP_BITS-1:0] exponent;

    modport source (output valid, base_value, exponent, input ready);
    modport sink   (input valid, base_value, exponent, output ready);
endinterface

interface mexp_rsp_if #(
    parameter int MOD_BITS = 31
);
    logic                valid;
    logic                ready;
    logic [MOD_BITS-1:0] power_result;

    modport source (output valid, power_result, input ready);
    modport sink   (input valid, power_result, output ready);
endinterface

### design/mexp_mulmod.sv
// Bit-serial modular multiplier: x * y mod m, one bit of x per cycle, MSB first.
// Requires y < m. Standalone, no package dependency.
module mexp_mulmod #(
    parameter int MOD_BITS = 31
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [MOD_BITS-1:0] i_x,
    input  logic [MOD_BITS-1:0] i_y,
    input  logic [MOD_BITS-1:0] i_m,
    output logic                o_done,
    output logic [MOD_BITS-1:0] o_res
);
    localparam int CW = (MOD_BITS > 1) ? $clog2(MOD_BITS) : 1;
    localparam logic [CW-1:0] LAST = CW'(MOD_BITS - 1);

    logic [MOD_BITS-1:0] r_acc, n_acc;
    logic [MOD_BITS-1:0] r_x;
    logic [MOD_BITS-1:0] r_y;
    logic [MOD_BITS-1:0] r_m;
    logic [CW-1:0]       r_cnt;
    logic                r_busy;
    logic                r_done;
    logic [MOD_BITS+1:0] t0, t1, t2, m_ext;

    // Double, add the selected multiplicand, reduce twice
    always_comb begin
        m_ext = {2'b00, r_m};
        t0 = {1'b0, r_acc, 1'b0} + (r_x[MOD_BITS-1] ? {2'b00, r_y} : '0);
        t1 = (t0 >= m_ext) ? t0 - m_ext : t0;
        t2 = (t1 >= m_ext) ? t1 - m_ext : t1;
        n_acc = t2[MOD_BITS-1:0];
    end

    // Control: busy flag, bit counter, done pulse
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == LAST);
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == LAST) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    // Operands and running residue
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_acc <= '0;
            r_x   <= i_x;
            r_y   <= i_y;
            r_m   <= i_m;
        end else if (r_busy) begin
            r_acc <= n_acc;
            r_x   <= {r_x[MOD_BITS-2:0], 1'b0};
        end
    end

    assign o_done = r_done;
    assign o_res  = r_acc;
endmodule

### design/mexp_dp.sv
// Datapath of the modular exponentiation block: operand registers, two product
// units, output register. Depends on mexp_pkg and mexp_mulmod.
module mexp_dp
    import mexp_pkg::*;
#(
    parameter int EXP_BITS = 63,
    parameter int MOD_BITS = 31
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_dp_cmd             i_cmd,
    output t_dp_status          o_status,
    input  logic [MOD_BITS-1:0] i_modulus,
    input  logic [MOD_BITS-1:0] i_base_value,
    input  logic [EXP_BITS-1:0] i_exponent,
    input  logic                i_out_ready,
    output logic                o_out_valid,
    output logic [MOD_BITS-1:0] o_power_result
);
    localparam logic [MOD_BITS-1:0] ONE = MOD_BITS'(1);

    logic [EXP_BITS-1:0] r_exp;
    logic [MOD_BITS-1:0] r_sq;
    logic [MOD_BITS-1:0] r_acc;
    logic [MOD_BITS-1:0] r_mod;
    logic                r_zero;
    logic                r_out_valid;
    logic [MOD_BITS-1:0] r_out;
    logic                sq_done, mul_done;
    logic [MOD_BITS-1:0] sq_res, mul_res;
    logic [MOD_BITS-1:0] sq_x, sq_y, sq_m;

    // Square unit also reduces the base: base * 1 mod m
    assign sq_x = i_cmd.load ? i_base_value : r_sq;
    assign sq_y = i_cmd.load ? ONE : r_sq;
    assign sq_m = i_cmd.load ? i_modulus : r_mod;

    mexp_mulmod #(.MOD_BITS(MOD_BITS)) u_sq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.load | i_cmd.start_step),
        .i_x     (sq_x),
        .i_y     (sq_y),
        .i_m     (sq_m),
        .o_done  (sq_done),
        .o_res   (sq_res)
    );

    mexp_mulmod #(.MOD_BITS(MOD_BITS)) u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.start_step),
        .i_x     (r_sq),
        .i_y     (r_acc),
        .i_m     (r_mod),
        .o_done  (mul_done),
        .o_res   (mul_res)
    );

    // Operand registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_exp  <= i_exponent;
            r_acc  <= ONE;
            r_mod  <= i_modulus;
            r_zero <= (i_modulus < MOD_BITS'(2));
        end
        if (i_cmd.take_red) begin
            r_sq <= sq_res;
        end
        if (i_cmd.take_step) begin
            r_sq  <= sq_res;
            r_exp <= r_exp >> 1;
            if (r_exp[0]) begin
                r_acc <= mul_res;
            end
        end
    end

    // Output register: hold until the transaction completes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.push) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_out <= r_zero ? '0 : r_acc;
        end
    end

    assign o_status.mul_done = sq_done & mul_done | sq_done & ~mul_done;
    assign o_status.exp_zero = (r_exp == '0);
    assign o_status.out_free = ~r_out_valid | i_out_ready;
    assign o_out_valid       = r_out_valid;
    assign o_power_result    = r_out;
endmodule

### design/mexp_ctrl.sv
// Controller of the modular exponentiation block: sequences reduction, steps
// and result hand-off. Depends on mexp_pkg.
module mexp_ctrl
    import mexp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd
);
    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_RED  = 5'b00010,
        S_LOOP = 5'b00100,
        S_MUL  = 5'b01000,
        S_DONE = 5'b10000
    } t_state;

    t_state r_state, n_state;

    // Next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_RED;
                end
            end
            S_RED: begin
                if (i_status.mul_done) begin
                    o_cmd.take_red = 1'b1;
                    n_state        = S_LOOP;
                end
            end
            S_LOOP: begin
                if (i_status.exp_zero) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.start_step = 1'b1;
                    n_state          = S_MUL;
                end
            end
            S_MUL: begin
                if (i_status.mul_done) begin
                    o_cmd.take_step = 1'b1;
                    n_state         = S_LOOP;
                end
            end
            S_DONE: begin
                if (i_status.out_free) begin
                    o_cmd.push = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);
endmodule

### design/modular_exponentiation.sv
// Top level of the modular exponentiation block.
// Depends on mexp_pkg, mexp_if, mexp_mulmod, mexp_dp and mexp_ctrl.
//
// Usage:
//   i_req (sink) takes base_value and exponent; o_rsp (source) returns
//   power_result = base_value ** exponent mod modulus, one per transaction.
//   The modulus is written through i_cfg_we / i_cfg_wdata while idle; a
//   modulus below two makes every result zero.
// Sequencing: one transaction at a time. After acceptance the base is reduced,
//   then each exponent bit up to the highest set one takes a step (square
//   and multiply run in parallel in two bit-serial product units, one
//   multiplier bit per cycle). The result is then loaded into the output
//   register, and the next request can be taken in the same cycle that the
//   result becomes valid.
// Stall: the result sits in an output register; a new request is taken while
//   it waits, and the next result waits for that register to drain.
// Reset: synchronous, active low; clears control state and loads the modulus
//   with 1000000007.
module modular_exponentiation
    import mexp_pkg::*;
#(
    parameter int EXP_BITS = 63,
    parameter int MOD_BITS = 31
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    mexp_req_if.sink            i_req,
    mexp_rsp_if.source          o_rsp,
    input  logic                i_cfg_we,
    input  logic [MOD_BITS-1:0] i_cfg_wdata
);
    logic [MOD_BITS-1:0] r_modulus;
    t_dp_cmd             cmd;
    t_dp_status          status;
    logic                in_ready;

    // Modulus register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_modulus <= MODULUS_RESET[MOD_BITS-1:0];
        end else if (i_cfg_we) begin
            r_modulus <= i_cfg_wdata;
        end
    end

    mexp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .o_in_ready (in_ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    mexp_dp #(.EXP_BITS(EXP_BITS), .MOD_BITS(MOD_BITS)) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_status       (status),
        .i_modulus      (r_modulus),
        .i_base_value   (i_req.base_value),
        .i_exponent     (i_req.exponent),
        .i_out_ready    (o_rsp.ready),
        .o_out_valid    (o_rsp.valid),
        .o_power_result (o_rsp.power_result)
    );

    assign i_req.ready = in_ready;

`ifndef SYNTHESIS
    // Result is a residue of the modulus
    a_res_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && r_modulus >= MOD_BITS'(2)) |-> (o_rsp.power_result < r_modulus))
        else $error("result not below modulus");

    // Degenerate modulus gives zero
    a_res_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && r_modulus < MOD_BITS'(2)) |-> (o_rsp.power_result == '0))
        else $error("nonzero result for modulus below two");

    // One transaction in flight
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready) |=> !i_req.ready)
        else $error("request taken while busy");
`endif
endmodule
